// File: rtl/assert_macros.svh
// Assertion macros for the language tag checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/ltc_pkg.sv
// Shared types, constants and the subtag action table of the language tag checker.
package ltc_pkg;

  localparam int MAX_TAG_CHARS = 84;
  localparam int POS_W = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int NUM_SUBTAGS = 7;

  localparam logic [3:0] LEN_SAT = 4'd9;
  localparam logic [3:0] SUBTAG_MAX_LEN = 4'd8;
  localparam logic [6:0] EXT_MIN_SPAN = 7'd3;
  localparam logic [6:0] PRIV_MIN_SPAN = 7'd2;

  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_LANGUAGE = 3'd0;
  localparam slot_t SLOT_EXTLANG = 3'd1;
  localparam slot_t SLOT_SCRIPT = 3'd2;
  localparam slot_t SLOT_REGION = 3'd3;
  localparam slot_t SLOT_VARIANT = 3'd4;
  localparam slot_t SLOT_EXTENSION = 3'd5;
  localparam slot_t SLOT_PRIVATE = 3'd6;
  localparam slot_t SLOT_TAG = 3'd7;

  typedef enum logic [1:0] {
    CK_LETTER,
    CK_DIGIT,
    CK_END,
    CK_OTHER
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic is_x;
    logic over;
    logic last;
    logic [POS_W-1:0] pos;
  } token_t;

  typedef enum logic [2:0] {
    PS_START,
    PS_LANGUAGE,
    PS_SCRIPT,
    PS_REGION,
    PS_VARIANT,
    PS_EXTENSION,
    PS_PRIVATE
  } parse_state_t;

  typedef enum logic [1:0] {
    BS_RUN,
    BS_TERM,
    BS_REPORT
  } back_state_t;

  typedef enum logic [3:0] {
    ACT_FAIL,
    ACT_LANG,
    ACT_EXTLANG_OR_REGION,
    ACT_IRREGULAR,
    ACT_SCRIPT_OR_VARIANT,
    ACT_VARIANT_DIGIT,
    ACT_REGION_ALPHA,
    ACT_REGION_NUM,
    ACT_VARIANT,
    ACT_SINGLETON,
    ACT_EXT_BODY,
    ACT_PRIV_BODY,
    ACT_IRREGULAR_END
  } action_t;

  function automatic action_t ltc_action(input logic [5:0] ix);
    action_t act;
    act = ACT_FAIL;
    if (ix inside {6'd1, 6'd9, 6'd17, 6'd25, 6'd33, 6'd41}) begin
      act = ACT_SINGLETON;
    end else if (ix inside {6'd2, 6'd3}) begin
      act = ACT_LANG;
    end else if (ix inside {6'd4, 6'd12, 6'd20}) begin
      act = ACT_SCRIPT_OR_VARIANT;
    end else if (ix inside {6'd10, 6'd18, 6'd26}) begin
      act = ACT_REGION_ALPHA;
    end else if (ix == 6'd11) begin
      act = ACT_EXTLANG_OR_REGION;
    end else if (ix inside {[6'd13:6'd16], [6'd21:6'd24], [6'd29:6'd32], [6'd37:6'd40]}) begin
      act = ACT_VARIANT;
    end else if (ix inside {6'd19, 6'd27}) begin
      act = ACT_REGION_NUM;
    end else if (ix inside {6'd28, 6'd36}) begin
      act = ACT_VARIANT_DIGIT;
    end else if (ix inside {6'd34, 6'd35}) begin
      act = ACT_IRREGULAR_END;
    end else if (ix inside {[6'd42:6'd48]}) begin
      act = ACT_EXT_BODY;
    end else if (ix inside {[6'd49:6'd56]}) begin
      act = ACT_PRIV_BODY;
    end
    return act;
  endfunction

endpackage

// File: rtl/language_tag_checker_core.sv
// Top level of the language tag checker: front end, token queue and parser.
// Throughput: one character per cycle while a tag streams in and the token queue is not full.
// A tag end passes through a terminator state (skipped for a bad length) and then a report state,
// which registers the eight slot results in order, holding each until out_ready takes it.
// Synchronous active-high reset empties the queue and returns the parser to its start state.
`include "assert_macros.svh"

module language_tag_checker_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               character,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                slot,
  output logic                      present,
  output logic [ltc_pkg::POS_W-1:0] start_res,
  output logic [ltc_pkg::POS_W-1:0] span,
  output logic                      well_formed,
  output logic                      grandfathered,
  output logic                      private_use,
  output logic                      end_of_run
);
  import ltc_pkg::*;

  token_t front_tok;
  token_t queue_tok;
  logic   tok_push;
  logic   tok_full;
  logic   tok_empty;
  logic   tok_pop;

  ltc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .last      (last),
    .tok_push  (tok_push),
    .tok       (front_tok),
    .tok_full  (tok_full)
  );

  ltc_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (tok_push),
    .wr_tok (front_tok),
    .full   (tok_full),
    .pop    (tok_pop),
    .rd_tok (queue_tok),
    .empty  (tok_empty)
  );

  ltc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tok_empty     (tok_empty),
    .tok           (queue_tok),
    .pop           (tok_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot          (slot),
    .present       (present),
    .start_res     (start_res),
    .span          (span),
    .well_formed   (well_formed),
    .grandfathered (grandfathered),
    .private_use   (private_use),
    .end_of_run    (end_of_run)
  );

  `ASSERT_IMP(a_pop_not_empty, clk, rst, tok_pop, !tok_empty)
  `ASSERT_IMP(a_absent_zero, clk, rst, out_valid && !present, start_res == '0 && span == '0)
  `ASSERT_NXT(a_slot_order, clk, rst, out_valid && out_ready && !end_of_run, out_valid && slot == 3'($past(slot) + 3'd1))
  `ASSERT_IMP(a_tag_slot_last, clk, rst, out_valid && end_of_run, present && slot == SLOT_TAG && start_res == '0)

endmodule

// File: rtl/ltc_fifo.sv
// Short token queue between the classifying front end and the parser.
module ltc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ltc_pkg::token_t wr_tok,
  output logic            full,
  input  logic            pop,
  output ltc_pkg::token_t rd_tok,
  output logic            empty
);
  import ltc_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign full = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign rd_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= FIFO_AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= FIFO_AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= (FIFO_AW+1)'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= (FIFO_AW+1)'(fill - 1'b1);
      end
    end
  end

endmodule

// File: rtl/ltc_front.sv
// Front end: classifies each character and tags it with its position in the tag.
module ltc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [15:0]     character,
  input  logic            last,
  output logic            tok_push,
  output ltc_pkg::token_t tok,
  input  logic            tok_full
);
  import ltc_pkg::*;

  logic [POS_W-1:0] char_count;
  logic [15:0]      folded;
  logic             is_letter;
  logic             is_digit;

  assign in_ready = !tok_full;
  assign tok_push = in_valid && in_ready;

  assign folded = character | 16'h0020;
  assign is_letter = folded inside {[16'h0061:16'h007A]};
  assign is_digit = character inside {[16'h0030:16'h0039]};

  always_comb begin
    if (is_letter) begin
      tok.kind = CK_LETTER;
    end else if (is_digit) begin
      tok.kind = CK_DIGIT;
    end else if (character == 16'h002D || character == 16'h0000) begin
      tok.kind = CK_END;
    end else begin
      tok.kind = CK_OTHER;
    end
    tok.is_x = (folded == 16'h0078);
    tok.over = (char_count >= POS_W'(MAX_TAG_CHARS));
    tok.last = last;
    tok.pos = char_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (tok_push) begin
      if (last) begin
        char_count <= '0;
      end else if (!tok.over) begin
        char_count <= POS_W'(char_count + 1'b1);
      end
    end
  end

endmodule

// File: rtl/ltc_back.sv
// Back end: runs the subtag parser on queued tokens and reports the eight slots.
module ltc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tok_empty,
  input  ltc_pkg::token_t               tok,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    slot,
  output logic                          present,
  output logic [ltc_pkg::POS_W-1:0]     start_res,
  output logic [ltc_pkg::POS_W-1:0]     span,
  output logic                          well_formed,
  output logic                          grandfathered,
  output logic                          private_use,
  output logic                          end_of_run
);
  import ltc_pkg::*;

  back_state_t               st, st_next;
  parse_state_t              parse_state, parse_state_next;
  logic                      still_valid, still_valid_next;
  logic                      finished, finished_next;
  logic                      seen_extlang, seen_extlang_next;
  logic                      open_extension, open_extension_next;
  logic                      has_letter, has_letter_next;
  logic                      has_digit, has_digit_next;
  logic [POS_W-1:0]          cur_start, cur_start_next;
  logic [3:0]                cur_len, cur_len_next;
  logic                      first_is_digit, first_is_digit_next;
  logic                      first_is_x, first_is_x_next;
  logic [NUM_SUBTAGS-1:0]    subtag_map, subtag_map_next;
  logic [POS_W-1:0]          slot_starts [NUM_SUBTAGS];
  logic [POS_W-1:0]          slot_starts_next [NUM_SUBTAGS];
  logic [POS_W-1:0]          slot_spans [NUM_SUBTAGS];
  logic [POS_W-1:0]          slot_spans_next [NUM_SUBTAGS];
  logic                      flag_gf, flag_gf_next;
  logic                      flag_priv, flag_priv_next;
  logic [POS_W-1:0]          tag_len, tag_len_next;
  slot_t                     rpt_idx, rpt_idx_next;

  token_t                    cur_tok;
  logic                      feed_en;
  logic                      alive;
  logic [5:0]                ix;
  action_t                   act;
  logic                      rec_en;
  slot_t                     rec_idx;
  parse_state_t              rec_next;
  logic                      rec_ok;
  logic                      do_fail;
  logic                      gf_end;
  logic                      out_load;
  logic                      wf;
  logic                      rpt_here;

  assign alive = still_valid && !finished;
  assign ix = 6'({parse_state, 3'b000}) + 6'(cur_len);
  assign act = ltc_action(ix);

  assign wf = still_valid
           && (parse_state != PS_EXTENSION || slot_spans[SLOT_EXTENSION] > EXT_MIN_SPAN)
           && (parse_state != PS_PRIVATE || slot_spans[SLOT_PRIVATE] > PRIV_MIN_SPAN);

  always_comb begin
    st_next = st;
    parse_state_next = parse_state;
    still_valid_next = still_valid;
    finished_next = finished;
    seen_extlang_next = seen_extlang;
    open_extension_next = open_extension;
    has_letter_next = has_letter;
    has_digit_next = has_digit;
    cur_start_next = cur_start;
    cur_len_next = cur_len;
    first_is_digit_next = first_is_digit;
    first_is_x_next = first_is_x;
    subtag_map_next = subtag_map;
    slot_starts_next = slot_starts;
    slot_spans_next = slot_spans;
    flag_gf_next = flag_gf;
    flag_priv_next = flag_priv;
    tag_len_next = tag_len;
    rpt_idx_next = rpt_idx;
    pop = 1'b0;
    feed_en = 1'b0;
    out_load = 1'b0;
    cur_tok = tok;
    rec_en = 1'b0;
    rec_idx = SLOT_LANGUAGE;
    rec_next = parse_state;
    rec_ok = 1'b1;
    do_fail = 1'b0;
    gf_end = 1'b0;

    case (st)
      BS_RUN: begin
        if (!tok_empty) begin
          pop = 1'b1;
          feed_en = 1'b1;
        end
      end
      BS_TERM: begin
        feed_en = 1'b1;
        cur_tok.kind = CK_END;
        cur_tok.is_x = 1'b0;
        cur_tok.over = 1'b0;
        cur_tok.last = 1'b0;
        cur_tok.pos = tag_len;
      end
      BS_REPORT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        st_next = BS_RUN;
      end
    endcase

    if (feed_en) begin
      if (cur_tok.over) begin
        do_fail = 1'b1;
      end else if (alive) begin
        case (cur_tok.kind)
          CK_LETTER, CK_DIGIT: begin
            if (cur_len == '0) begin
              cur_start_next = cur_tok.pos;
              first_is_digit_next = (cur_tok.kind == CK_DIGIT);
              first_is_x_next = cur_tok.is_x;
            end
            if (cur_len != LEN_SAT) begin
              cur_len_next = 4'(cur_len + 1'b1);
            end
            if (cur_tok.kind == CK_LETTER) begin
              has_letter_next = 1'b1;
            end else begin
              has_digit_next = 1'b1;
            end
          end
          CK_END: begin
            if (cur_len != '0 && cur_len <= SUBTAG_MAX_LEN) begin
              case (act)
                ACT_LANG: begin
                  rec_en = 1'b1;
                  rec_ok = !has_digit;
                  rec_idx = SLOT_LANGUAGE;
                  rec_next = PS_LANGUAGE;
                end
                ACT_EXTLANG_OR_REGION: begin
                  if (has_digit) begin
                    if (has_letter) begin
                      do_fail = 1'b1;
                    end else begin
                      rec_en = 1'b1;
                      rec_idx = SLOT_REGION;
                      rec_next = PS_VARIANT;
                    end
                  end else if (seen_extlang) begin
                    do_fail = 1'b1;
                  end else begin
                    rec_en = 1'b1;
                    rec_idx = SLOT_EXTLANG;
                    rec_next = PS_LANGUAGE;
                    seen_extlang_next = 1'b1;
                  end
                end
                ACT_IRREGULAR: begin
                  flag_gf_next = 1'b1;
                  rec_en = 1'b1;
                  rec_ok = !has_digit;
                  rec_idx = SLOT_LANGUAGE;
                  rec_next = PS_SCRIPT;
                end
                ACT_SCRIPT_OR_VARIANT: begin
                  rec_en = 1'b1;
                  if (has_digit) begin
                    rec_ok = first_is_digit;
                    rec_idx = SLOT_VARIANT;
                    rec_next = PS_VARIANT;
                  end else begin
                    rec_idx = SLOT_REGION;
                    rec_next = PS_SCRIPT;
                  end
                end
                ACT_VARIANT_DIGIT: begin
                  rec_en = 1'b1;
                  rec_ok = first_is_digit;
                  rec_idx = SLOT_VARIANT;
                  rec_next = PS_VARIANT;
                end
                ACT_REGION_ALPHA: begin
                  if (has_digit) begin
                    do_fail = 1'b1;
                  end else begin
                    rec_en = 1'b1;
                    rec_idx = SLOT_REGION;
                    rec_next = PS_VARIANT;
                  end
                end
                ACT_REGION_NUM: begin
                  if (has_letter) begin
                    do_fail = 1'b1;
                  end else begin
                    rec_en = 1'b1;
                    rec_idx = SLOT_REGION;
                    rec_next = PS_VARIANT;
                  end
                end
                ACT_VARIANT: begin
                  rec_en = 1'b1;
                  rec_idx = SLOT_VARIANT;
                  rec_next = PS_VARIANT;
                end
                ACT_SINGLETON: begin
                  if (open_extension) begin
                    do_fail = 1'b1;
                  end else if (first_is_x) begin
                    rec_en = 1'b1;
                    rec_idx = SLOT_PRIVATE;
                    rec_next = PS_PRIVATE;
                  end else if (cur_start != '0) begin
                    open_extension_next = 1'b1;
                    rec_en = 1'b1;
                    rec_idx = SLOT_EXTENSION;
                    rec_next = PS_EXTENSION;
                  end else begin
                    gf_end = 1'b1;
                  end
                end
                ACT_EXT_BODY: begin
                  open_extension_next = 1'b0;
                  rec_en = 1'b1;
                  rec_idx = SLOT_EXTENSION;
                  rec_next = PS_EXTENSION;
                end
                ACT_PRIV_BODY: begin
                  flag_priv_next = 1'b1;
                  rec_en = 1'b1;
                  rec_idx = SLOT_PRIVATE;
                  rec_next = PS_PRIVATE;
                end
                ACT_IRREGULAR_END: begin
                  gf_end = 1'b1;
                end
                default: begin
                  do_fail = 1'b1;
                end
              endcase
              has_letter_next = 1'b0;
              has_digit_next = 1'b0;
              cur_len_next = '0;
              cur_start_next = '0;
            end else begin
              do_fail = 1'b1;
            end
          end
          default: begin
            do_fail = 1'b1;
          end
        endcase
      end
    end

    if (rec_en) begin
      if (subtag_map[rec_idx]) begin
        slot_spans_next[rec_idx] = POS_W'(slot_spans[rec_idx] + POS_W'(cur_len) + 1'b1);
      end else begin
        subtag_map_next[rec_idx] = 1'b1;
        slot_starts_next[rec_idx] = cur_start;
        slot_spans_next[rec_idx] = POS_W'(cur_len);
      end
      parse_state_next = rec_next;
      still_valid_next = rec_ok;
    end
    if (do_fail) begin
      still_valid_next = 1'b0;
      finished_next = 1'b1;
    end
    if (gf_end) begin
      finished_next = 1'b1;
      if (!flag_gf) begin
        still_valid_next = 1'b0;
      end
    end

    if (st == BS_RUN && pop && tok.last) begin
      if (!tok.over && tok.pos != '0) begin
        tag_len_next = POS_W'(tok.pos + 1'b1);
        st_next = BS_TERM;
      end else begin
        subtag_map_next = '0;
        flag_gf_next = 1'b0;
        flag_priv_next = 1'b0;
        still_valid_next = 1'b0;
        tag_len_next = '0;
        st_next = BS_REPORT;
      end
    end
    if (st == BS_TERM) begin
      st_next = BS_REPORT;
    end

    if (out_load) begin
      rpt_idx_next = 3'(rpt_idx + 1'b1);
      if (rpt_idx == SLOT_TAG) begin
        st_next = BS_RUN;
        rpt_idx_next = SLOT_LANGUAGE;
        parse_state_next = PS_START;
        still_valid_next = 1'b1;
        finished_next = 1'b0;
        seen_extlang_next = 1'b0;
        open_extension_next = 1'b0;
        has_letter_next = 1'b0;
        has_digit_next = 1'b0;
        cur_len_next = '0;
        subtag_map_next = '0;
        flag_gf_next = 1'b0;
        flag_priv_next = 1'b0;
      end
    end
  end

  always_comb begin
    if (rpt_idx == SLOT_TAG) begin
      rpt_here = 1'b1;
    end else begin
      rpt_here = subtag_map[rpt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BS_RUN;
      parse_state <= PS_START;
      still_valid <= 1'b1;
      finished <= 1'b0;
      seen_extlang <= 1'b0;
      open_extension <= 1'b0;
      has_letter <= 1'b0;
      has_digit <= 1'b0;
      cur_len <= '0;
      subtag_map <= '0;
      flag_gf <= 1'b0;
      flag_priv <= 1'b0;
      rpt_idx <= SLOT_LANGUAGE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      parse_state <= parse_state_next;
      still_valid <= still_valid_next;
      finished <= finished_next;
      seen_extlang <= seen_extlang_next;
      open_extension <= open_extension_next;
      has_letter <= has_letter_next;
      has_digit <= has_digit_next;
      cur_len <= cur_len_next;
      subtag_map <= subtag_map_next;
      flag_gf <= flag_gf_next;
      flag_priv <= flag_priv_next;
      rpt_idx <= rpt_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_start <= cur_start_next;
    first_is_digit <= first_is_digit_next;
    first_is_x <= first_is_x_next;
    slot_starts <= slot_starts_next;
    slot_spans <= slot_spans_next;
    tag_len <= tag_len_next;
    if (out_load) begin
      slot <= rpt_idx;
      present <= rpt_here;
      well_formed <= wf;
      grandfathered <= flag_gf;
      private_use <= flag_priv;
      end_of_run <= (rpt_idx == SLOT_TAG);
      if (rpt_idx == SLOT_TAG) begin
        start_res <= '0;
        span <= tag_len;
      end else if (rpt_here) begin
        start_res <= slot_starts[rpt_idx];
        span <= slot_spans[rpt_idx];
      end else begin
        start_res <= '0;
        span <= '0;
      end
    end
  end

endmodule

// File: verif/language_tag_checker_core_tb.sv
// Self-checking testbench for language_tag_checker_core: directed and random tags.
`timescale 1ns / 100ps

module language_tag_checker_core_tb;
  import ltc_pkg::*;

  localparam logic [15:0] HYPHEN = 16'h002D;
  localparam logic [15:0] NUL = 16'h0000;
  localparam logic [15:0] LETTER_X = 16'h0078;
  localparam int MAX_SHOWN = 10;

  typedef enum {
    SUB_ALPHA,
    SUB_DIGIT,
    SUB_ALNUM,
    SUB_LEAD_DIGIT
  } sub_kind_t;

  typedef struct packed {
    slot_t            slot;
    logic             present;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] span;
    logic             wf;
    logic             gf;
    logic             pu;
    logic             eor;
  } slot_report_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [15:0]      character;
  logic             last;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       slot;
  logic             present;
  logic [POS_W-1:0] start_res;
  logic [POS_W-1:0] span;
  logic             well_formed;
  logic             grandfathered;
  logic             private_use;
  logic             end_of_run;

  slot_report_t reports_due[$];
  logic [15:0]  draft[$];
  bit           steady = 1'b0;
  int           mismatches = 0;

  parse_state_t     pstate;
  logic             alive;
  logic             done;
  logic             had_extlang;
  logic             ext_open;
  logic [6:0]       n_letters;
  logic [6:0]       n_digits;
  logic [POS_W-1:0] sub_start;
  logic [6:0]       sub_len;
  logic             lead_digit;
  logic             lead_x;
  logic [POS_W-1:0] chars_seen;
  logic [7:0]       slot_seen;
  logic [POS_W-1:0] slot_start [8];
  logic [POS_W-1:0] slot_span [8];
  logic             gf_flag;
  logic             pu_flag;

  language_tag_checker_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .character(character),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .slot(slot),
    .present(present),
    .start_res(start_res),
    .span(span),
    .well_formed(well_formed),
    .grandfathered(grandfathered),
    .private_use(private_use),
    .end_of_run(end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic action_t subtag_action(int ix);
    case (ix)
      1, 9, 17, 25, 33, 41: return ACT_SINGLETON;
      2, 3: return ACT_LANG;
      4, 12, 20: return ACT_SCRIPT_OR_VARIANT;
      10, 18, 26: return ACT_REGION_ALPHA;
      11: return ACT_EXTLANG_OR_REGION;
      13, 14, 15, 16, 21, 22, 23, 24, 29, 30, 31, 32, 37, 38, 39, 40: return ACT_VARIANT;
      19, 27: return ACT_REGION_NUM;
      28, 36: return ACT_VARIANT_DIGIT;
      34, 35: return ACT_IRREGULAR_END;
      42, 43, 44, 45, 46, 47, 48: return ACT_EXT_BODY;
      49, 50, 51, 52, 53, 54, 55, 56: return ACT_PRIV_BODY;
      default: return ACT_FAIL;
    endcase
  endfunction

  function automatic void tag_clear();
    pstate = PS_START;
    alive = 1'b1;
    done = 1'b0;
    had_extlang = 1'b0;
    ext_open = 1'b0;
    n_letters = '0;
    n_digits = '0;
    sub_start = '0;
    sub_len = '0;
    lead_digit = 1'b0;
    lead_x = 1'b0;
    chars_seen = '0;
    slot_seen = '0;
    slot_seen[SLOT_TAG] = 1'b1;
    foreach (slot_start[i]) begin
      slot_start[i] = '0;
      slot_span[i] = '0;
    end
    gf_flag = 1'b0;
    pu_flag = 1'b0;
  endfunction

  function automatic void halt();
    alive = 1'b0;
    done = 1'b1;
  endfunction

  function automatic void irregular_end();
    done = 1'b1;
    if (!gf_flag) alive = 1'b0;
  endfunction

  function automatic void close_slot(logic ok, slot_t idx, parse_state_t nxt);
    if (slot_seen[idx]) begin
      slot_span[idx] = slot_span[idx] + sub_len + 7'd1;
    end else begin
      slot_seen[idx] = 1'b1;
      slot_start[idx] = sub_start;
      slot_span[idx] = sub_len;
    end
    pstate = nxt;
    alive = ok;
  endfunction

  function automatic void close_subtag();
    case (subtag_action(8 * int'(pstate) + int'(sub_len)))
      ACT_LANG: close_slot(n_digits == 0, SLOT_LANGUAGE, PS_LANGUAGE);
      ACT_EXTLANG_OR_REGION: begin
        if (n_digits != 0) begin
          if (n_letters != 0) halt();
          else close_slot(1'b1, SLOT_REGION, PS_VARIANT);
        end else if (had_extlang) begin
          halt();
        end else begin
          close_slot(1'b1, SLOT_EXTLANG, PS_LANGUAGE);
          had_extlang = 1'b1;
        end
      end
      ACT_SCRIPT_OR_VARIANT: begin
        if (n_digits != 0) close_slot(lead_digit, SLOT_VARIANT, PS_VARIANT);
        else close_slot(1'b1, SLOT_REGION, PS_SCRIPT);
      end
      ACT_VARIANT_DIGIT: close_slot(lead_digit, SLOT_VARIANT, PS_VARIANT);
      ACT_REGION_ALPHA: begin
        if (n_digits != 0) halt();
        else close_slot(1'b1, SLOT_REGION, PS_VARIANT);
      end
      ACT_REGION_NUM: begin
        if (n_letters != 0) halt();
        else close_slot(1'b1, SLOT_REGION, PS_VARIANT);
      end
      ACT_VARIANT: close_slot(1'b1, SLOT_VARIANT, PS_VARIANT);
      ACT_SINGLETON: begin
        if (ext_open) begin
          halt();
        end else if (lead_x) begin
          close_slot(1'b1, SLOT_PRIVATE, PS_PRIVATE);
        end else if (sub_start != 0) begin
          ext_open = 1'b1;
          close_slot(1'b1, SLOT_EXTENSION, PS_EXTENSION);
        end else begin
          irregular_end();
        end
      end
      ACT_EXT_BODY: begin
        ext_open = 1'b0;
        close_slot(1'b1, SLOT_EXTENSION, PS_EXTENSION);
      end
      ACT_PRIV_BODY: begin
        pu_flag = 1'b1;
        close_slot(1'b1, SLOT_PRIVATE, PS_PRIVATE);
      end
      ACT_IRREGULAR_END: irregular_end();
      default: halt();
    endcase
    n_letters = '0;
    n_digits = '0;
    sub_len = '0;
    sub_start = '0;
  endfunction

  function automatic void take_char(logic [15:0] c, logic [POS_W-1:0] pos);
    logic [15:0] folded;
    logic        is_letter;
    logic        is_digit;
    folded = c | 16'h0020;
    is_letter = (folded - 16'h0061) <= 16'd25;
    is_digit = (c - 16'h0030) <= 16'd9;
    if (!alive || done) return;
    if (is_letter || is_digit) begin
      if (sub_len == 0) begin
        sub_start = pos;
        lead_digit = is_digit;
        lead_x = (folded == LETTER_X);
      end
      if (sub_len < 7'd127) sub_len++;
      if (is_letter) begin
        if (n_letters < 7'd127) n_letters++;
      end else if (n_digits < 7'd127) begin
        n_digits++;
      end
    end else if ((c == HYPHEN || c == NUL) && sub_len != 0 && sub_len <= 7'd8) begin
      close_subtag();
    end else begin
      halt();
    end
  endfunction

  // Advance the parse by one transaction; queue the slot reports at tag end.
  function automatic void parse_char(logic [15:0] c, logic lst);
    logic [POS_W-1:0] n;
    logic             wf_now;
    slot_report_t     r;
    if (chars_seen >= MAX_TAG_CHARS) begin
      halt();
      chars_seen = POS_W'(MAX_TAG_CHARS + 1);
    end else begin
      take_char(c, chars_seen);
      chars_seen++;
    end
    if (!lst) return;
    n = chars_seen;
    if (n >= 2 && n <= MAX_TAG_CHARS) begin
      take_char(NUL, n);
      slot_start[SLOT_TAG] = '0;
      slot_span[SLOT_TAG] = n;
      wf_now = alive && (pstate != PS_EXTENSION || slot_span[SLOT_EXTENSION] > EXT_MIN_SPAN)
               && (pstate != PS_PRIVATE || slot_span[SLOT_PRIVATE] > PRIV_MIN_SPAN);
    end else begin
      slot_seen = '0;
      slot_seen[SLOT_TAG] = 1'b1;
      foreach (slot_start[i]) begin
        slot_start[i] = '0;
        slot_span[i] = '0;
      end
      gf_flag = 1'b0;
      pu_flag = 1'b0;
      wf_now = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      r.slot = slot_t'(k);
      r.present = slot_seen[k];
      r.start = slot_seen[k] ? slot_start[k] : '0;
      r.span = slot_seen[k] ? slot_span[k] : '0;
      r.wf = wf_now;
      r.gf = gf_flag;
      r.pu = pu_flag;
      r.eor = (k == 7);
      reports_due.push_back(r);
    end
    tag_clear();
  endfunction

  function automatic logic [15:0] pick_char(sub_kind_t kind);
    logic [15:0] letter;
    letter = 16'h0061 + 16'($urandom_range(0, 25));
    if ($urandom_range(0, 1)) letter = letter & ~16'h0020;
    case (kind)
      SUB_ALPHA: return letter;
      SUB_DIGIT: return 16'h0030 + 16'($urandom_range(0, 9));
      default: return ($urandom_range(0, 3) == 0) ? 16'h0030 + 16'($urandom_range(0, 9)) : letter;
    endcase
  endfunction

  function automatic logic [15:0] noise_char();
    case ($urandom_range(0, 5))
      0: return HYPHEN;
      1: return NUL;
      2: return 16'h0040;
      3: return 16'h005F;
      4: return 16'($urandom_range(0, 65535));
      default: return pick_char(SUB_ALNUM);
    endcase
  endfunction

  function automatic void add_subtag(sub_kind_t kind, int len);
    if (draft.size() != 0) draft.push_back(HYPHEN);
    for (int i = 0; i < len; i++) begin
      if (kind == SUB_LEAD_DIGIT) draft.push_back(pick_char(i == 0 ? SUB_DIGIT : SUB_ALNUM));
      else draft.push_back(pick_char(kind));
    end
  endfunction

  function automatic void load_text(string s);
    draft.delete();
    for (int i = 0; i < s.len(); i++) draft.push_back(16'(s[i]));
  endfunction

  task automatic send_char(logic [15:0] c, logic lst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    character <= c;
    last <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    parse_char(c, lst);
    @(negedge clk);
  endtask

  task automatic send_draft();
    foreach (draft[i]) send_char(draft[i], i == draft.size() - 1);
  endtask

  task automatic send_text(string s);
    load_text(s);
    send_draft();
  endtask

  task automatic test_length_limits();
    send_text("a");
    send_text("en");
    load_text("en-US");
    repeat (9) add_subtag(SUB_ALPHA, 7);
    add_subtag(SUB_ALPHA, 6);
    send_draft();
    load_text("en-US");
    repeat (10) add_subtag(SUB_ALPHA, 7);
    send_draft();
    load_text("en");
    repeat (14) add_subtag(SUB_ALNUM, 6);
    send_draft();
  endtask

  task automatic test_subtag_forms();
    send_text("en-US");
    send_text("zh-yue-HK");
    send_text("sr-Latn-RS");
    send_text("sr-Latn-419");
    send_text("es-419");
    send_text("de-CH-1901");
    send_text("en-US-1994-rozaj");
    send_text("sl-1abc");
    send_text("en-a-bcd-efgh-x-priv-12");
    send_text("x-abc");
    send_text("i-klingon");
    send_text("en-US-ab");
    send_text("en-a");
    send_text("en-x");
    send_text("zh-yue-abc-12");
  endtask

  task automatic test_bad_characters();
    send_text("e@n-US");
    send_text("en--US");
    send_text("en-");
    send_text("abcdefghi-en");
    draft = '{16'h0065, 16'h006E, NUL, 16'h0055, 16'h0053};
    send_draft();
    draft = '{16'hFFFF, 16'h0061};
    send_draft();
  endtask

  // Mostly well-formed tags with random content; the rest mutated or pure noise.
  task automatic test_random_tags();
    int sent;
    int shape;
    bit priv;
    sent = 0;
    while (sent < 130) begin
      steady = ($urandom_range(0, 3) == 0);
      draft.delete();
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
        repeat ($urandom_range(1, 10)) draft.push_back(noise_char());
      end else begin
        priv = ($urandom_range(0, 7) == 0);
        if (priv) begin
          draft.push_back(LETTER_X);
        end else begin
          add_subtag(SUB_ALPHA, ($urandom_range(0, 5) == 0) ? $urandom_range(4, 8)
                                                              : $urandom_range(2, 3));
          if ($urandom_range(0, 4) == 0) add_subtag(SUB_ALPHA, 3);
          if ($urandom_range(0, 2) == 0) add_subtag(SUB_ALPHA, 4);
          if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) add_subtag(SUB_ALPHA, 2);
            else add_subtag(SUB_DIGIT, 3);
          end
          if ($urandom_range(0, 3) == 0) add_subtag(SUB_LEAD_DIGIT, 4);
          else if ($urandom_range(0, 3) == 0) add_subtag(SUB_ALNUM, $urandom_range(5, 8));
          if ($urandom_range(0, 3) == 0) begin
            add_subtag(SUB_ALNUM, 1);
            if ((draft[draft.size() - 1] | 16'h0020) == LETTER_X) begin
              draft[draft.size() - 1] = 16'h0061;
            end
            repeat ($urandom_range(1, 2)) add_subtag(SUB_ALNUM, $urandom_range(2, 8));
          end
          priv = ($urandom_range(0, 3) == 0);
          if (priv) begin
            draft.push_back(HYPHEN);
            draft.push_back(LETTER_X);
          end
        end
        if (priv) repeat ($urandom_range(1, 2)) add_subtag(SUB_ALNUM, $urandom_range(1, 8));
        if (shape == 8) draft[$urandom_range(0, draft.size() - 1)] = noise_char();
      end
      sent += draft.size();
      send_draft();
    end
    steady = 1'b0;
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    slot_report_t want;
    slot_report_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{slot, present, start_res, span, well_formed, grandfathered, private_use,
              end_of_run};
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: unexpected result for slot %0d", $realtime, got.slot);
        end
      end else begin
        want = reports_due.pop_front();
        if (got.slot !== want.slot || got.present !== want.present ||
            got.start !== want.start || got.span !== want.span || got.wf !== want.wf ||
            got.gf !== want.gf || got.pu !== want.pu || got.eor !== want.eor) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: expected slot=%0d present=%0b start=%0d span=%0d wf=%0b gf=%0b pu=%0b eor=%0b",
                     $realtime, want.slot, want.present, want.start, want.span, want.wf,
                     want.gf, want.pu, want.eor);
            $display("%0t: actual   slot=%0d present=%0b start=%0d span=%0d wf=%0b gf=%0b pu=%0b eor=%0b",
                     $realtime, got.slot, got.present, got.start, got.span, got.wf,
                     got.gf, got.pu, got.eor);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL language_tag_checker_core");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    character = '0;
    last = 1'b0;
    tag_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_length_limits();
    test_subtag_forms();
    test_bad_characters();
    test_random_tags();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASS language_tag_checker_core");
    end else begin
      $display("FAIL language_tag_checker_core");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ltc_pkg.sv
rtl/ltc_fifo.sv
rtl/ltc_front.sv
rtl/ltc_back.sv
rtl/language_tag_checker_core.sv
verif/language_tag_checker_core_tb.sv
